// ===== hw/rtl/mmhlc_pkg.sv =====
// shared types, constants and helpers for the min/max height level classifier
package mmhlc_pkg;

    localparam int HEIGHT_BITS_DEF = 16;
    localparam int SCALE_BITS      = 10;
    localparam int SCALE           = 1000;
    localparam int UNIT_SPAN       = 16;
    localparam int LEVEL_COUNT     = 7;
    localparam int LEVEL_BITS      = 3;

    localparam logic ACT_SCAN     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SCALE,
        ST_COMPARE
    } ctrl_state_t;

    typedef struct packed {
        logic scan;
        logic capture;
        logic stage_span;
        logic stage_scale;
        logic load_out;
    } dp_cmd_t;

    // level thresholds in thousandths of the span
    function automatic logic [SCALE_BITS-1:0] level_mark(input logic [LEVEL_BITS-1:0] idx);
        logic [SCALE_BITS-1:0] mark;
        unique case (idx)
            3'd0:    mark = 10'd50;
            3'd1:    mark = 10'd150;
            3'd2:    mark = 10'd300;
            3'd3:    mark = 10'd550;
            3'd4:    mark = 10'd700;
            3'd5:    mark = 10'd850;
            3'd6:    mark = 10'd950;
            default: mark = '0;
        endcase
        return mark;
    endfunction

endpackage

// ===== hw/rtl/mmhlc_ctrl.sv =====
// sequencing controller: input handshake, classify steps and output register valid
module mmhlc_ctrl
    import mmhlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    action,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_take;
    logic        out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (action == ACT_CLASSIFY))
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.scan    = in_take && (action == ACT_SCAN);
                cmd.capture = in_take && (action == ACT_CLASSIFY);
            end
            ST_SPAN:
            begin
                cmd.stage_span = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.stage_scale = 1'b1;
            end
            ST_COMPARE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/mmhlc_datapath.sv =====
// datapath: running min/max, span and offset, scaled compares, level count
module mmhlc_datapath
    import mmhlc_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    input  logic [HEIGHT_BITS-1:0] height,
    input  logic                   first,
    output logic [LEVEL_BITS-1:0]  material
);

    localparam int PW = HEIGHT_BITS + SCALE_BITS;

    logic [HEIGHT_BITS-1:0] lowest_reg;
    logic [HEIGHT_BITS-1:0] lowest_next;
    logic [HEIGHT_BITS-1:0] highest_reg;
    logic [HEIGHT_BITS-1:0] highest_next;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [HEIGHT_BITS-1:0] diff_reg;
    logic [HEIGHT_BITS-1:0] diff_next;
    logic [HEIGHT_BITS-1:0] span_reg;
    logic [HEIGHT_BITS-1:0] span_next;
    logic                   below_reg;
    logic                   below_next;
    logic                   below_s2_reg;
    logic [PW-1:0]          scaled_reg;
    logic [PW-1:0]          scaled_next;
    logic [PW-1:0]          mark_reg [LEVEL_COUNT];
    logic [PW-1:0]          mark_next [LEVEL_COUNT];
    logic [LEVEL_BITS-1:0]  material_reg;
    logic [LEVEL_BITS-1:0]  material_next;

    // running minimum and maximum
    always_comb
    begin
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        if (cmd.scan)
        begin
            if (first)
            begin
                lowest_next  = height;
                highest_next = height;
            end
            else
            begin
                if (height < lowest_reg)
                begin
                    lowest_next = height;
                end
                if (height > highest_reg)
                begin
                    highest_next = height;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= '1;
            highest_reg <= '0;
        end
        else
        begin
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
        end
    end

    // flat or empty range falls back to a span of UNIT_SPAN (16)
    always_comb
    begin
        below_next = (height_reg < lowest_reg);
        diff_next  = height_reg - lowest_reg;
        if (highest_reg > lowest_reg)
        begin
            span_next = highest_reg - lowest_reg;
        end
        else
        begin
            span_next = HEIGHT_BITS'(UNIT_SPAN);
        end
    end

    // constant multiples only: shift-add products
    always_comb
    begin
        scaled_next = PW'(diff_reg) * PW'(SCALE);
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            mark_next[i] = PW'(span_reg) * PW'(level_mark(LEVEL_BITS'(i)));
        end
    end

    always_comb
    begin
        material_next = '0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (scaled_reg >= mark_reg[i])
            begin
                material_next = material_next + LEVEL_BITS'(1);
            end
        end
        if (below_s2_reg)
        begin
            material_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            height_reg <= height;
        end
        if (cmd.stage_span)
        begin
            below_reg <= below_next;
            diff_reg  <= diff_next;
            span_reg  <= span_next;
        end
        if (cmd.stage_scale)
        begin
            below_s2_reg <= below_reg;
            scaled_reg   <= scaled_next;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                mark_reg[i] <= mark_next[i];
            end
        end
        if (cmd.load_out)
        begin
            material_reg <= material_next;
        end
    end

    assign material = material_reg;

endmodule

// ===== hw/rtl/min_max_height_level_classifier.sv =====
// top level of the min/max height level classifier
//
// input channel (in_valid/in_stall) carries action, height and first. a scan
// transaction (action 0) folds height into the running minimum and maximum,
// or restarts both from height when first is set; it gives no result and the
// block takes the next transaction in the following cycle.
// a classify transaction (action 1) gives one material on the output channel
// (out_valid/out_stall): the height offset from the minimum times 1000 is
// compared against seven threshold multiples of the span.
// a classify passes through each step in turn from acceptance to
// out_valid; the next transaction is taken once the result sits in the
// output register, so classify items do not overlap in the three-step compare
// sequence (span, scale, compare) in the shared datapath; scans run at one
// per cycle while no classify is in progress.
// the output register holds a result while out_stall is high; a new classify
// may be accepted meanwhile and then waits in its last step for the slot.
// reset clears the sequencer and output valid, sets the minimum to all ones
// and the maximum to zero, so a classify before any scan uses a span of 16.
module min_max_height_level_classifier
    import mmhlc_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [HEIGHT_BITS-1:0] height,
    input  logic                   first,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_BITS-1:0]  material
);

    dp_cmd_t cmd;

    mmhlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mmhlc_datapath #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .height   (height),
        .first    (first),
        .material (material)
    );

`ifndef SYNTHESIS
    // a scan never blocks the next transaction
    a_scan_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == ACT_SCAN)) |=> !in_stall)
        else $error("input stalled after a scan transaction");

    // classify occupies the sequencer for its compare steps
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == ACT_CLASSIFY)) |=> in_stall ##1 in_stall)
        else $error("input accepted during classify sequence");

    // a new result appears only at the end of a classify sequence
    a_result_from_classify: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced outside a classify sequence");
`endif

endmodule
